// ----- rtl/electronic_fuse_trip_assert.svh -----
// Assertion macros for the electronic fuse trip block
`ifndef ELECTRONIC_FUSE_TRIP_ASSERT_SVH
`define ELECTRONIC_FUSE_TRIP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EFT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define EFT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFT_ASSERT(lbl, prop, msg)
`define EFT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/efuse_pkg.sv -----
// Types and constants shared by the electronic fuse trip modules
package efuse_pkg;

	localparam int unsigned RAW_W     = 12;
	localparam int unsigned MA_W      = 16;
	localparam int unsigned ZSUM_W    = 15;
	localparam int unsigned CAL_W     = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CAL_W-1:0] CAL_SAMPLES    = 3'd5;
	localparam logic [MA_W-1:0]  MIN_CURRENT_MA = 16'd100;
	localparam logic [11:0]      MA_SCALE       = 12'd2500;

	localparam logic [MA_W-1:0] INSTANT_RESET = 16'd4000;
	localparam logic [MA_W-1:0] TIMED_RESET   = 16'd2000;
	localparam logic [MA_W-1:0] DELAY_RESET   = 16'd25;

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INSTANT = 2'd0,
		REG_TIMED   = 2'd1,
		REG_DELAY   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [RAW_W-1:0] adc_raw;
	} in_t;

	typedef struct packed {
		logic [MA_W-1:0] current_ma;
		logic [MA_W-1:0] peak_ma;
		logic            switch_on;
		logic            armed;
		logic            trip_event;
		logic            calibrated;
	} out_t;

	typedef struct packed {
		logic [MA_W-1:0] instant_limit_ma;
		logic [MA_W-1:0] timed_limit_ma;
		logic [MA_W-1:0] trip_delay;
	} limits_t;

endpackage

// ----- rtl/efuse_conv.sv -----
// Raw ADC sample to milliamps against the learned zero offset
module efuse_conv import efuse_pkg::*; (
	input  logic [ZSUM_W-1:0] zero_sum,
	input  logic [RAW_W-1:0]  adc_raw,
	output logic [MA_W-1:0]   current_ma
);

	logic [ZSUM_W-1:0] raw_x5;
	logic [ZSUM_W+1:0] diff;
	logic              positive;
	logic [26:0]       prod;
	logic [16:0]       ma;

	always_comb begin
		raw_x5   = {1'b0, adc_raw, 2'b00} + {3'b000, adc_raw};
		diff     = {2'b00, zero_sum} - {2'b00, raw_x5};
		positive = !diff[ZSUM_W+1] && (diff != '0);
		prod     = {12'd0, diff[ZSUM_W-1:0]} * {15'd0, MA_SCALE};
		ma       = prod[26:10];
		if (!positive) begin
			current_ma = '0;
		end else if (ma[16]) begin
			current_ma = '1;
		end else if (ma[MA_W-1:0] < MIN_CURRENT_MA) begin
			current_ma = '0;
		end else begin
			current_ma = ma[MA_W-1:0];
		end
	end

endmodule

// ----- rtl/efuse_ctrl.sv -----
// Calibration, peak tracking, trip logic and switch state
module efuse_ctrl import efuse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  in_t     item,
	input  limits_t limits,
	output out_t    res
);

	logic [ZSUM_W-1:0] zero_sum_q, zero_sum_d;
	logic [CAL_W-1:0]  calib_left_q, calib_left_d;
	logic [MA_W-1:0]   peak_q, peak_d;
	logic [MA_W-1:0]   delay_q, delay_d;
	logic              armed_q, armed_d;
	logic              switch_q, switch_d;
	logic [MA_W-1:0]   conv_ma;
	logic [MA_W-1:0]   cur;
	logic              trip;

	efuse_conv u_conv (
		.zero_sum   (zero_sum_d),
		.adc_raw    (item.adc_raw),
		.current_ma (conv_ma)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_sum_q   <= '0;
			calib_left_q <= CAL_SAMPLES;
			peak_q       <= '0;
			delay_q      <= '0;
			armed_q      <= 1'b1;
			switch_q     <= 1'b0;
		end else if (step) begin
			zero_sum_q   <= zero_sum_d;
			calib_left_q <= calib_left_d;
			peak_q       <= peak_d;
			delay_q      <= delay_d;
			armed_q      <= armed_d;
			switch_q     <= switch_d;
		end
	end

	always_comb begin
		zero_sum_d   = zero_sum_q;
		calib_left_d = calib_left_q;
		peak_d       = peak_q;
		delay_d      = delay_q;
		armed_d      = armed_q;
		switch_d     = switch_q;
		cur          = '0;
		trip         = 1'b0;
		if (item.cmd == CMD_SAMPLE && calib_left_q != '0) begin
			zero_sum_d   = zero_sum_q + {3'b000, item.adc_raw};
			calib_left_d = calib_left_q - 1'b1;
		end
		case (item.cmd)
			CMD_SAMPLE: begin
				if (calib_left_d == '0)
					cur = conv_ma;
				if (cur > peak_q)
					peak_d = cur;
				if (armed_q) begin
					if (cur >= limits.instant_limit_ma) begin
						trip = 1'b1;
					end else if (cur >= limits.timed_limit_ma) begin
						if (delay_q != '0)
							delay_d = delay_q - 1'b1;
						if (delay_d == '0)
							trip = 1'b1;
					end else begin
						delay_d = limits.trip_delay;
					end
				end
				if (trip)
					switch_d = 1'b0;
			end
			CMD_ENABLE: begin
				armed_d  = 1'b1;
				peak_d   = '0;
				delay_d  = limits.trip_delay;
				switch_d = 1'b1;
			end
			CMD_DISABLE: begin
				armed_d  = 1'b0;
				switch_d = 1'b1;
			end
			default: ;
		endcase
		res.current_ma = cur;
		res.peak_ma    = peak_d;
		res.switch_on  = switch_d;
		res.armed      = armed_d;
		res.trip_event = trip;
		res.calibrated = (calib_left_d == '0);
	end

endmodule

// ----- rtl/electronic_fuse_trip.sv -----
// Electronic fuse trip: top level with input, config and result registers
//
// Input channel in_valid/in_ready/in_data carries a command and a raw 12-bit
// current sample. Every transfer yields exactly one result on
// out_valid/out_ready/out_data: current in mA, peak, switch, armed, trip and
// calibrated flags. The first five samples learn the zero offset.
// Result valid rises once the item has moved from the input register into
// the result register; one item is taken every cycle while out_ready stays
// high. The state update and conversion for an item are combinational
// between the input register and the result register.
// A stalled receiver holds the result register; one more item can sit in
// the input register, after which in_ready drops until the result moves.
// Limits are written on cfg_valid/cfg_ready/cfg_index/cfg_data (always
// ready, index 0 instant limit, 1 timed limit, 2 trip delay, 3 ignored).
// The user must write limits only while no item is in flight (unguarded).
// Reset (arst_n low) empties both registers, loads the default limits,
// restarts calibration, arms protection and turns the switch off.
`include "electronic_fuse_trip_assert.svh"
module electronic_fuse_trip import efuse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MA_W-1:0]      cfg_data
);

	logic    valid_s1;
	in_t     item_s1;
	logic    out_valid_q;
	out_t    out_q;
	limits_t limits_q;
	logic    advance;
	out_t    res;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.instant_limit_ma <= INSTANT_RESET;
			limits_q.timed_limit_ma   <= TIMED_RESET;
			limits_q.trip_delay       <= DELAY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INSTANT: limits_q.instant_limit_ma <= cfg_data;
				REG_TIMED:   limits_q.timed_limit_ma   <= cfg_data;
				REG_DELAY:   limits_q.trip_delay       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	efuse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.limits (limits_q),
		.res    (res)
	);

	`EFT_ASSERT(a_trip_opens, out_valid_q && out_q.trip_event |-> !out_q.switch_on, "trip left switch on")
	`EFT_ASSERT(a_trip_armed, out_valid_q && out_q.trip_event |-> out_q.armed, "trip while disarmed")
	`EFT_ASSERT(a_cur_valid, out_valid_q && out_q.current_ma != '0 |-> out_q.calibrated && out_q.current_ma >= MIN_CURRENT_MA, "bad current")
	`EFT_ASSERT(a_peak_ge, out_valid_q |-> out_q.peak_ma >= out_q.current_ma, "peak below current")
	`EFT_ASSERT(a_ready_free, !out_valid_q |-> in_ready, "input blocked with empty output")
	`EFT_ASSERT_RST(a_rst_empty, !arst_n |=> !out_valid_q || arst_n, "output valid out of reset")

endmodule

// ----- verif/tb_electronic_fuse_trip.sv -----
// Self-checking testbench for the electronic fuse trip block: directed table, then random phases
`timescale 1ns / 100ps
module tb_electronic_fuse_trip;
	import efuse_pkg::*;

	localparam logic [1:0]           CMD_UNUSED      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;
	localparam int                   PHASES          = 8;
	localparam int                   ITEMS_PER_PHASE = 116;
	localparam int                   HOLD_CYCLES     = 80;
	localparam int                   STALL_LIMIT     = 2000;
	localparam int                   WALK_ROWS       = 22;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} walk_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MA_W-1:0]      cfg_data  = '0;

	// shadow of the fuse state and limits
	logic [ZSUM_W-1:0] zsum;
	logic [CAL_W-1:0]  cal_left;
	logic [MA_W-1:0]   peak;
	logic [MA_W-1:0]   dcount;
	logic              armed_q;
	logic              switch_q;
	limits_t           lim;

	out_t      fuse_results_due[$];
	walk_row_t walk[WALK_ROWS];
	int        mismatches  = 0;
	int        items_sent  = 0;
	int        stall_count = 0;
	int        hold_left   = 0;
	bit        hold_req    = 0;
	bit        no_gaps     = 0;

	electronic_fuse_trip dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic out_t fuse_next(in_t it);
		int             diff;
		int             m;
		logic [MA_W-1:0] ma;
		logic           trip;
		out_t           r;
		ma = '0;
		trip = 1'b0;
		case (it.cmd)
		CMD_SAMPLE: begin
			if (cal_left != 0) begin
				zsum = zsum + it.adc_raw;
				cal_left = cal_left - 1'b1;
			end
			if (cal_left == 0) begin
				diff = int'(zsum) - 5 * int'(it.adc_raw);
				if (diff > 0) begin
					m = (diff * 2500) >> 10;
					if (m >= int'(MIN_CURRENT_MA))
						ma = (m > 65535) ? 16'hFFFF : m[15:0];
				end
			end
			if (ma > peak)
				peak = ma;
			if (armed_q) begin
				if (ma >= lim.instant_limit_ma) begin
					trip = 1'b1;
				end else if (ma >= lim.timed_limit_ma) begin
					if (dcount != 0)
						dcount = dcount - 1'b1;
					if (dcount == 0)
						trip = 1'b1;
				end else begin
					dcount = lim.trip_delay;
				end
			end
			if (trip)
				switch_q = 1'b0;
		end
		CMD_ENABLE: begin
			armed_q = 1'b1;
			peak = '0;
			dcount = lim.trip_delay;
			switch_q = 1'b1;
		end
		CMD_DISABLE: begin
			armed_q = 1'b0;
			switch_q = 1'b1;
		end
		default: ;
		endcase
		r.current_ma = ma;
		r.peak_ma = peak;
		r.switch_on = switch_q;
		r.armed = armed_q;
		r.trip_event = trip;
		r.calibrated = (cal_left == 0);
		return r;
	endfunction

	// raw reading that yields at least the given current for the learned offset
	function automatic logic [RAW_W-1:0] raw_for_ma(int ma);
		int r;
		r = (int'(zsum) - (ma * 1024 + 2499) / 2500) / 5;
		if (r < 0)
			r = 0;
		if (r > 4095)
			r = 4095;
		return r[RAW_W-1:0];
	endfunction

	task automatic send_item(in_t it, bit typed, out_t want);
		out_t got;
		while (!no_gaps && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		got = fuse_next(it);
		fuse_results_due.push_back(typed ? want : got);
	endtask

	task automatic offer(logic [1:0] cmd, logic [RAW_W-1:0] raw);
		in_t it;
		it.cmd = cmd;
		it.adc_raw = raw;
		send_item(it, 1'b0, '0);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_INSTANT: lim.instant_limit_ma = val;
		REG_TIMED:   lim.timed_limit_ma = val;
		REG_DELAY:   lim.trip_delay = val;
		default: ;
		endcase
	endtask

	task automatic set_limits(logic [MA_W-1:0] inst, logic [MA_W-1:0] timed,
			logic [MA_W-1:0] dly);
		write_reg(REG_INSTANT, inst);
		write_reg(REG_TIMED, timed);
		write_reg(REG_DELAY, dly);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (fuse_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_t want;
		if (out_valid && out_ready) begin
			if (fuse_results_due.size() == 0) begin
				$display("%0t: result with none pending, expected nothing actual %h",
					$time, out_data);
				mismatches++;
			end else begin
				want = fuse_results_due.pop_front();
				check_field("current_ma", want.current_ma, out_data.current_ma);
				check_field("peak_ma", want.peak_ma, out_data.peak_ma);
				check_field("switch_on", want.switch_on, out_data.switch_on);
				check_field("armed", want.armed, out_data.armed);
				check_field("trip_event", want.trip_event, out_data.trip_event);
				check_field("calibrated", want.calibrated, out_data.calibrated);
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_gaps || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stall_count);
			$display("tb_electronic_fuse_trip: FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		int lo;
		int hi;
		int n;
		int inst;
		// offset learned from five full-scale readings: zero sum 20475, raw 0 gives 49987 mA
		walk = '{
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd0}, 1, '{16'd49987, 16'd49987, 1'b0, 1'b1, 1'b1, 1'b1}},
			'{'{CMD_ENABLE, 12'd0}, 1, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd4095}, 1, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd4094}, 1, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd4054}, 0, '0},
			'{'{CMD_SAMPLE, 12'd0}, 1, '{16'd49987, 16'd49987, 1'b0, 1'b1, 1'b1, 1'b1}},
			'{'{CMD_SAMPLE, 12'd0}, 1, '{16'd49987, 16'd49987, 1'b0, 1'b1, 1'b1, 1'b1}},
			'{'{CMD_DISABLE, 12'd0}, 1, '{16'd0, 16'd49987, 1'b1, 1'b0, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd0}, 1, '{16'd49987, 16'd49987, 1'b1, 1'b0, 1'b0, 1'b1}},
			'{'{CMD_UNUSED, 12'hABC}, 1, '{16'd0, 16'd49987, 1'b1, 1'b0, 1'b0, 1'b1}},
			'{'{CMD_ENABLE, 12'hFFF}, 1, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
			'{'{CMD_SAMPLE, 12'd3849}, 0, '0},
			'{'{CMD_SAMPLE, 12'd3849}, 0, '0},
			'{'{CMD_SAMPLE, 12'h555}, 0, '0},
			'{'{CMD_SAMPLE, 12'hAAA}, 0, '0},
			'{'{CMD_DISABLE, 12'h555}, 0, '0},
			'{'{CMD_ENABLE, 12'hAAA}, 0, '0}
		};
		zsum = '0;
		cal_left = CAL_SAMPLES;
		peak = '0;
		dcount = '0;
		armed_q = 1'b1;
		switch_q = 1'b0;
		lim = '{INSTANT_RESET, TIMED_RESET, DELAY_RESET};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (walk[i])
			send_item(walk[i].item, walk[i].typed, walk[i].want);
		in_valid <= 1'b0;
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2)
				write_reg(REG_SPARE, 16'($urandom));
			case (p)
			0: set_limits(16'd0, 16'd0, 16'd0);
			1: set_limits(16'd50000, 16'd50000, 16'd65535);
			default: begin
				inst = $urandom_range(50000, 500);
				set_limits(16'(inst), 16'($urandom_range(inst, 0)),
					16'($urandom_range(12, 1)));
			end
			endcase
			no_gaps = (p == 2 || p == 3);
			// long receiver hold-off while the sender keeps offering
			if (p == 2)
				hold_req = 1'b1;
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) begin
				kind = $urandom_range(99);
				lo = lim.timed_limit_ma;
				hi = (lim.instant_limit_ma == 0) ? 0 : int'(lim.instant_limit_ma) - 1;
				if (kind < 45) begin
					n = (lim.trip_delay > 36) ? 40 : int'(lim.trip_delay) + 3;
					n = $urandom_range(n, 1);
					repeat (n)
						offer(CMD_SAMPLE, raw_for_ma($urandom_range(hi, lo)));
				end else if (kind < 65) begin
					repeat ($urandom_range(6, 1))
						offer(CMD_SAMPLE, 12'($urandom_range(4095)));
				end else if (kind < 75) begin
					offer(CMD_SAMPLE, raw_for_ma($urandom_range(50000, lim.instant_limit_ma)));
				end else if (kind < 85) begin
					offer(CMD_SAMPLE, raw_for_ma($urandom_range(lo)));
				end else if (kind < 92) begin
					offer(CMD_ENABLE, 12'($urandom_range(4095)));
				end else if (kind < 98) begin
					offer(CMD_DISABLE, 12'($urandom_range(4095)));
				end else begin
					offer(CMD_UNUSED, 12'($urandom_range(4095)));
				end
			end
			in_valid <= 1'b0;
			drain();
		end
		no_gaps = 0;

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_electronic_fuse_trip: PASS");
		else
			$display("tb_electronic_fuse_trip: FAIL");
		$finish;
	end

endmodule
